### hdl/csvt_pkg.sv
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared codes, characters and token types of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  // Parse states
  localparam logic [2:0] ST_ROW_START   = 3'd0;
  localparam logic [2:0] ST_FIELD_START = 3'd1;
  localparam logic [2:0] ST_UNQUOTED    = 3'd2;
  localparam logic [2:0] ST_QUOTED      = 3'd3;
  localparam logic [2:0] ST_QUOTE_SEEN  = 3'd4;
  localparam logic [2:0] ST_AFTER_CR    = 3'd5;

  // Token kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;

  // Input operations
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Characters
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [2:0] next_state;
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } step_t;

endpackage

### hdl/csvt_step.sv
// ----------------------------------------------------------------------------
// CSV tokenizer step
// Decodes one registered input against the parse state: next state and up
// to two tokens.
// ----------------------------------------------------------------------------
module csvt_step import csvt_pkg::*; (
  input  logic [2:0] state,
  input  logic [7:0] delimiter,
  input  logic       op,
  input  logic [7:0] text_byte,
  output step_t      step
);

  // Token builders
  function automatic tok_t mk_tok(input logic [1:0] kind, input logic [7:0] b);
    tok_t t;
    t.kind = kind;
    t.data = (kind == KIND_BYTE) ? b : 8'd0;
    t.last = 1'b0;
    return t;
  endfunction

  // Byte outside a quoted field; split ends the row before a content byte
  function automatic step_t plain(input logic [7:0] c, input logic [7:0] d,
                                  input logic split);
    step_t s;
    s = '0;
    if (c == d) begin
      s.count      = 2'd1;
      s.tok0       = mk_tok(KIND_FIELD, 8'd0);
      s.next_state = ST_FIELD_START;
    end else if (c == CH_CR) begin
      s.count      = 2'd1;
      s.tok0       = mk_tok(KIND_ROW, 8'd0);
      s.next_state = ST_AFTER_CR;
    end else if (c == CH_LF) begin
      s.count      = 2'd1;
      s.tok0       = mk_tok(KIND_ROW, 8'd0);
      s.next_state = ST_ROW_START;
    end else if (split) begin
      s.count      = 2'd2;
      s.tok0       = mk_tok(KIND_ROW, 8'd0);
      s.tok1       = mk_tok(KIND_BYTE, c);
      s.next_state = ST_UNQUOTED;
    end else begin
      s.count      = 2'd1;
      s.tok0       = mk_tok(KIND_BYTE, c);
      s.next_state = ST_UNQUOTED;
    end
    return s;
  endfunction

  // Start of a field: an opening quote wins over the delimiter
  function automatic step_t field_begin(input logic [7:0] c, input logic [7:0] d);
    step_t s;
    s = '0;
    if (c == CH_QUOTE) begin
      s.next_state = ST_QUOTED;
    end else begin
      s = plain(c, d, 1'b0);
    end
    return s;
  endfunction

  step_t s;

  // State decode
  always_comb begin
    s = '0;
    if (op == OP_END) begin
      if (state == ST_FIELD_START || state == ST_UNQUOTED ||
          state == ST_QUOTED || state == ST_QUOTE_SEEN) begin
        s.count = 2'd1;
        s.tok0  = mk_tok(KIND_ROW, 8'd0);
      end
      s.next_state = ST_ROW_START;
    end else begin
      unique case (state)
        ST_UNQUOTED: begin
          s = plain(text_byte, delimiter, 1'b0);
        end
        ST_QUOTED: begin
          if (text_byte == CH_QUOTE) begin
            s.next_state = ST_QUOTE_SEEN;
          end else begin
            s.count      = 2'd1;
            s.tok0       = mk_tok(KIND_BYTE, text_byte);
            s.next_state = ST_QUOTED;
          end
        end
        ST_QUOTE_SEEN: begin
          if (text_byte == CH_QUOTE) begin
            s.count      = 2'd1;
            s.tok0       = mk_tok(KIND_BYTE, CH_QUOTE);
            s.next_state = ST_QUOTED;
          end else begin
            s = plain(text_byte, delimiter, 1'b1);
          end
        end
        ST_AFTER_CR: begin
          if (text_byte == CH_LF) begin
            s.next_state = ST_ROW_START;
          end else begin
            s = field_begin(text_byte, delimiter);
          end
        end
        default: begin
          s = field_begin(text_byte, delimiter);
        end
      endcase
    end
  end

  // Mark the final token of this transaction
  always_comb begin
    step           = s;
    step.tok0.last = (s.count == 2'd1);
    step.tok1.last = (s.count == 2'd2);
  end

endmodule

### hdl/csvt_queue.sv
// ----------------------------------------------------------------------------
// CSV tokenizer result queue
// Small token queue: takes up to two tokens a cycle, delivers one a cycle while pop is high.
// ----------------------------------------------------------------------------
module csvt_queue import csvt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  tok_t              tok0,
  input  tok_t              tok1,
  input  logic              pop,
  output tok_t              head,
  output logic [QCNT_W-1:0] count
);

  tok_t              entries [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] wr_ptr_1;
  logic [QCNT_W-1:0] count_next;

  assign wr_ptr_1 = wr_ptr + QPTR_W'(1);
  assign head     = entries[rd_ptr];

  // Token storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= tok0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_1] <= tok1;
    end
  end

  // Occupancy
  always_comb begin
    count_next = count + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      count  <= count_next;
    end
  end

endmodule

### hdl/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Streaming CSV tokenizer: text bytes in, field bytes and field/row ends out.
// ----------------------------------------------------------------------------
// Each accepted input is held in an input register, decoded against the
// parse state and written into a four-entry token queue, whose head drives
// the output. An input can be taken every cycle while the queue has room.
// The output port delivers one token a cycle while out_stall is low, so the
// sustained rate is one input per cycle while each input yields at most
// one token, and an input that yields two tokens (text after a closing
// quote) delivers them one after the other. The input register advances
// only when the queue has room for two tokens. The delimiter resets to a
// comma and is written through cfg_write / cfg_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
module csv_field_tokenizer_core import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] text_byte,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_kind,
  output logic [7:0] field_byte,
  output logic       run_last
);

  logic [7:0]        delimiter;
  logic [2:0]        parse_state;
  logic              in_full;
  logic              in_op;
  logic [7:0]        in_byte;
  logic              advance;
  logic              pop;
  logic [1:0]        push_n;
  logic [QCNT_W-1:0] q_count;
  step_t             step;
  tok_t              head;

  // Delimiter register
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (cfg_write) begin
      delimiter <= cfg_data;
    end
  end

  // Input register moves on when the queue can take two tokens
  assign advance  = in_full && (q_count <= QCNT_W'(QDEPTH - 2));
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op   <= op;
      in_byte <= text_byte;
    end
  end

  // Parse step
  csvt_step u_step (
    .state     (parse_state),
    .delimiter (delimiter),
    .op        (in_op),
    .text_byte (in_byte),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_ROW_START;
    end else if (advance) begin
      parse_state <= step.next_state;
    end
  end

  // Token queue
  assign push_n = advance ? step.count : 2'd0;
  assign pop    = out_valid && !out_stall;

  csvt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .tok0   (step.tok0),
    .tok1   (step.tok1),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  assign out_valid  = (q_count != '0);
  assign token_kind = head.kind;
  assign field_byte = head.data;
  assign run_last   = head.last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QDEPTH))
    else $error("token queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_END |=> parse_state == ST_ROW_START)
    else $error("end of text did not return to row start");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    parse_state <= ST_AFTER_CR)
    else $error("parse state out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && q_count > QCNT_W'(QDEPTH - 2))
    else $error("input stalled without cause");

endmodule
